FILE: hdl/assert_macros.svh
// Assertion macros for the checker file of the framed command receiver.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, clocked and disabled during reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, clocked and disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/fcr_pkg.sv
// Package of the framed command receiver: constants, operation codes, result type.
// No dependencies.
`default_nettype none

package fcr_pkg;

	localparam int FCR_BUFFER_DEPTH   = 256;
	localparam int FCR_TIMEOUT_RELOAD = 200;

	localparam logic [7:0] START_USERS = 8'hF0;
	localparam logic [7:0] START_MSG   = 8'hF1;
	localparam logic [7:0] START_PRIO  = 8'hF2;
	localparam logic [7:0] QUERY_BYTE  = 8'hF3;
	localparam logic [7:0] NACK_BYTE   = 8'hF4;
	localparam logic [7:0] PING_BYTE   = 8'h74;
	localparam logic [7:0] PONG_BYTE   = 8'h54;
	localparam logic [7:0] DIGIT_ZERO  = 8'h30;

	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_CONSUME = 2'd1,
		OP_TICK    = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	// result of one item, less the buffer byte that comes from the registered RAM read
	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        message_pending;
		logic [31:0] user_count;
		logic [7:0]  idle_timeout;
		logic        rd_sel;
	} core_res_t;

endpackage

`default_nettype wire

FILE: hdl/fcr_cmd_if.sv
// Command channel of the framed command receiver: valid/ready plus item fields.
// Depends on nothing.
`default_nettype none

interface fcr_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] rx_byte;
	logic [7:0] read_index;

	modport source (output valid, op, rx_byte, read_index, input ready);
	modport sink   (input valid, op, rx_byte, read_index, output ready);
endinterface

`default_nettype wire

FILE: hdl/fcr_rsp_if.sv
// Response channel of the framed command receiver: valid/ready plus result fields.
// Depends on nothing.
`default_nettype none

interface fcr_rsp_if;
	logic        valid;
	logic        ready;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        message_pending;
	logic [31:0] user_count;
	logic [7:0]  idle_timeout;
	logic [7:0]  read_data;

	modport source (output valid, tx_valid, tx_byte, message_pending, user_count,
		idle_timeout, read_data, input ready);
	modport sink   (input valid, tx_valid, tx_byte, message_pending, user_count,
		idle_timeout, read_data, output ready);
endinterface

`default_nettype wire

FILE: hdl/fcr_ram.sv
// Generic single-write, single-read synchronous RAM with registered, enabled read.
// No dependencies.
`default_nettype none

module fcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/fcr_core.sv
// Frame engine: holds the scalar state, decodes each item, drives the frame store write
// and read ports. Depends on fcr_pkg.
`default_nettype none

module fcr_core #(
	parameter int BUFFER_DEPTH   = fcr_pkg::FCR_BUFFER_DEPTH,
	parameter int TIMEOUT_RELOAD = fcr_pkg::FCR_TIMEOUT_RELOAD
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            accept,
	input  wire logic [1:0]                      op,
	input  wire logic [7:0]                      rx_byte,
	input  wire logic [7:0]                      read_index,
	output logic                                 mem_we,
	output logic      [$clog2(BUFFER_DEPTH)-1:0] mem_waddr,
	output logic      [7:0]                      mem_wdata,
	output logic                                 mem_re,
	output logic      [$clog2(BUFFER_DEPTH)-1:0] mem_raddr,
	output fcr_pkg::core_res_t                   res
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int FW = $clog2(BUFFER_DEPTH + 1);

	logic [FW-1:0] fill_q,    fill_n;
	logic          pend_q,    pend_n;
	logic [31:0]   users_q,   users_n;
	logic [31:0]   acc_q,     acc_n;
	logic [7:0]    timeout_q, timeout_n;
	// copies of frame positions 0 and 1 for the completion test
	logic [7:0]    head_q,    head_n;
	logic [7:0]    len_q,     len_n;

	logic       tx_v;
	logic [7:0] tx_b;
	logic       rd_sel;
	logic       is_start;

	assign is_start = (rx_byte == fcr_pkg::START_USERS) || (rx_byte == fcr_pkg::START_MSG)
		|| (rx_byte == fcr_pkg::START_PRIO);

	always_comb begin
		fill_n    = fill_q;
		pend_n    = pend_q;
		users_n   = users_q;
		acc_n     = acc_q;
		timeout_n = timeout_q;
		head_n    = head_q;
		len_n     = len_q;
		tx_v      = 1'b0;
		tx_b      = 8'h00;
		rd_sel    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = fill_q[AW-1:0];
		unique case (fcr_pkg::op_t'(op))
			fcr_pkg::OP_BYTE: begin
				if (rx_byte == fcr_pkg::PING_BYTE) begin
					tx_v      = 1'b1;
					tx_b      = fcr_pkg::PONG_BYTE;
					timeout_n = 8'(TIMEOUT_RELOAD);
				end else if (rx_byte == fcr_pkg::QUERY_BYTE) begin
					tx_v = 1'b1;
					tx_b = pend_q ? fcr_pkg::NACK_BYTE : fcr_pkg::QUERY_BYTE;
				end else if (!pend_q) begin
					if (is_start) begin
						mem_we    = 1'b1;
						mem_waddr = '0;
						head_n    = rx_byte;
						fill_n    = FW'(1);
						acc_n     = '0;
					end else begin
						if (fill_q < FW'(BUFFER_DEPTH)) begin
							mem_we = 1'b1;
							if (fill_q == FW'(0)) begin
								head_n = rx_byte;
							end
							if (fill_q == FW'(1)) begin
								len_n = rx_byte;
							end
							if (fill_q >= FW'(2)) begin
								acc_n = (acc_q << 3) + (acc_q << 1) + 32'(rx_byte)
									- 32'(fcr_pkg::DIGIT_ZERO);
							end
							fill_n = fill_q + FW'(1);
						end
						if ((fill_n > FW'(1)) && (9'(fill_n) == 9'(len_n) + 9'd2)) begin
							tx_v = 1'b1;
							tx_b = head_n;
							if (head_n == fcr_pkg::START_USERS) begin
								users_n = acc_n;
							end else if ((head_n == fcr_pkg::START_MSG)
								|| (head_n == fcr_pkg::START_PRIO)) begin
								pend_n = 1'b1;
							end
						end
					end
				end
			end
			fcr_pkg::OP_CONSUME: begin
				pend_n = 1'b0;
			end
			fcr_pkg::OP_TICK: begin
				if (timeout_q != 8'd0) begin
					timeout_n = timeout_q - 8'd1;
				end
			end
			fcr_pkg::OP_READ: begin
				rd_sel = ({1'b0, read_index} < 9'(BUFFER_DEPTH));
			end
			default: begin
			end
		endcase
	end

	assign mem_wdata = rx_byte;
	assign mem_re    = accept && rd_sel;
	assign mem_raddr = read_index[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			pend_q    <= 1'b0;
			users_q   <= '0;
			acc_q     <= '0;
			timeout_q <= '0;
		end else if (accept) begin
			fill_q    <= fill_n;
			pend_q    <= pend_n;
			users_q   <= users_n;
			acc_q     <= acc_n;
			timeout_q <= timeout_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_q <= head_n;
			len_q  <= len_n;
		end
	end

	always_comb begin
		res.tx_valid        = tx_v;
		res.tx_byte         = tx_b;
		res.message_pending = pend_n;
		res.user_count      = users_n;
		res.idle_timeout    = timeout_n;
		res.rd_sel          = rd_sel;
	end

endmodule

`default_nettype wire

FILE: hdl/framed_command_receiver.sv
// Framed command receiver: one item a cycle in, its result out of the output register.
// Each item passes the first stage, then the output register, where the registered store read joins it.
// Throughput: one item per cycle while results are taken; a held result stalls the
// input once the first stage and the output register both hold an item.
// Reset (arst_n, async, active low) clears fill count, pending flag, user count,
// digit accumulator, timeout and pipeline valids; the frame store is not cleared.
`default_nettype none

module framed_command_receiver #(
	parameter int BUFFER_DEPTH   = fcr_pkg::FCR_BUFFER_DEPTH,
	parameter int TIMEOUT_RELOAD = fcr_pkg::FCR_TIMEOUT_RELOAD
) (
	input wire logic  clk,
	input wire logic  arst_n,
	fcr_cmd_if.sink   cmd,
	fcr_rsp_if.source rsp
);

	localparam int AW = $clog2(BUFFER_DEPTH);

	// handshake and pipeline control
	logic cmd_xfer;
	logic s1_move;
	logic valid_s1;
	logic out_valid_q;

	// frame store ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	fcr_pkg::core_res_t core_res;
	fcr_pkg::core_res_t res_s1;
	fcr_pkg::core_res_t out_q;
	logic [7:0]         rdata_q;

	// Advance the first stage when the output register is empty or being drained.
	assign s1_move   = valid_s1 && (!out_valid_q || rsp.ready);
	// Take a new transfer whenever the first stage is empty or moving on.
	assign cmd.ready = !valid_s1 || s1_move;
	assign cmd_xfer  = cmd.valid && cmd.ready;

	// Decode the item and update the scalar state in the accepting cycle;
	// the frame store write lands on the same edge.
	fcr_core #(
		.BUFFER_DEPTH  (BUFFER_DEPTH),
		.TIMEOUT_RELOAD(TIMEOUT_RELOAD)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (cmd_xfer),
		.op        (cmd.op),
		.rx_byte   (cmd.rx_byte),
		.read_index(cmd.read_index),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.res       (core_res)
	);

	// Frame store. The read data register holds while the first stage stalls,
	// since a read is only issued on an accepted transfer.
	fcr_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we && cmd_xfer),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// valid bits of the two stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_xfer) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload of the two stages; read data joins at the output register
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			res_s1 <= core_res;
		end
		if (s1_move) begin
			out_q   <= res_s1;
			rdata_q <= res_s1.rd_sel ? mem_rdata : 8'h00;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.tx_valid        = out_q.tx_valid;
	assign rsp.tx_byte         = out_q.tx_byte;
	assign rsp.message_pending = out_q.message_pending;
	assign rsp.user_count      = out_q.user_count;
	assign rsp.idle_timeout    = out_q.idle_timeout;
	assign rsp.read_data       = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/fcr_checker.sv
// Port-level checker for the framed command receiver, bound to the top level.
// Depends on fcr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fcr_checker #(
	parameter int TIMEOUT_RELOAD = fcr_pkg::FCR_TIMEOUT_RELOAD
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic        rsp_tx_valid,
	input wire logic [7:0]  rsp_tx_byte,
	input wire logic        rsp_message_pending,
	input wire logic [7:0]  rsp_idle_timeout
);

	// hold a result until it is taken
	`ASSERT_AT(a_rsp_hold, clk, arst_n, (rsp_valid && !rsp_ready) |=> rsp_valid, "result dropped before transfer")
	// no reply means a zero reply byte
	`ASSERT_IMPL(a_tx_idle_zero, clk, arst_n, rsp_valid && !rsp_tx_valid, rsp_tx_byte == 8'h00, "reply byte without tx_valid")
	// NACK only while a message is pending
	`ASSERT_IMPL(a_nack_pending, clk, arst_n, rsp_valid && rsp_tx_valid && (rsp_tx_byte == fcr_pkg::NACK_BYTE), rsp_message_pending, "NACK with no pending message")
	// timeout never above its reload value
	`ASSERT_IMPL(a_timeout_range, clk, arst_n, rsp_valid, rsp_idle_timeout <= 8'(TIMEOUT_RELOAD), "idle timeout above reload")

endmodule

bind framed_command_receiver fcr_checker #(
	.TIMEOUT_RELOAD(TIMEOUT_RELOAD)
) u_fcr_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_tx_valid       (rsp.tx_valid),
	.rsp_tx_byte        (rsp.tx_byte),
	.rsp_message_pending(rsp.message_pending),
	.rsp_idle_timeout   (rsp.idle_timeout)
);

`default_nettype wire

FILE: bench/tb_framed_command_receiver.sv
// Self-checking bench for the framed command receiver: a directed table, then random traffic.
// Depends on fcr_pkg, fcr_cmd_if, fcr_rsp_if and framed_command_receiver from hdl.
// Each result is checked in order against the bench's model, or against the row's want where typed is set.
`default_nettype none

module tb_framed_command_receiver;

	// one result as it leaves the response channel
	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        message_pending;
		logic [31:0] user_count;
		logic [7:0]  idle_timeout;
		logic [7:0]  read_data;
	} reply_t;

	// one row of the directed table; want is used only where typed is set
	typedef struct packed {
		fcr_pkg::op_t op;
		logic [7:0]   rx;
		logic [7:0]   idx;
		logic         typed;
		reply_t       want;
	} stim_row_t;

	localparam reply_t NO_REPLY = '0;
	localparam int     N_ROWS   = 24;

	// Directed stimulus: reset state, ping and query, bytes before any start byte,
	// a user-count frame, a pending message with NACK and ignored bytes, consume and read.
	localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{fcr_pkg::OP_TICK, 8'h00, 8'h00, 1'b1,
			'{1'b0, 8'h00, 1'b0, 32'd0, 8'd0, 8'h00}},
		'{fcr_pkg::OP_CONSUME, 8'h00, 8'h00, 1'b1,
			'{1'b0, 8'h00, 1'b0, 32'd0, 8'd0, 8'h00}},
		'{fcr_pkg::OP_BYTE, fcr_pkg::QUERY_BYTE, 8'h00, 1'b1,
			'{1'b1, fcr_pkg::QUERY_BYTE, 1'b0, 32'd0, 8'd0, 8'h00}},
		'{fcr_pkg::OP_BYTE, fcr_pkg::PING_BYTE, 8'h00, 1'b1,
			'{1'b1, fcr_pkg::PONG_BYTE, 1'b0, 32'd0, 8'd200, 8'h00}},
		'{fcr_pkg::OP_TICK, 8'h00, 8'h00, 1'b1,
			'{1'b0, 8'h00, 1'b0, 32'd0, 8'd199, 8'h00}},
		'{fcr_pkg::OP_BYTE,    8'hFF,                8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_BYTE,    8'h00,                8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_READ,    8'h00,                8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_BYTE,    fcr_pkg::START_USERS, 8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_BYTE,    8'h03,                8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_BYTE,    8'h31,                8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_BYTE,    8'h32,                8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_BYTE,    8'h39,                8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_BYTE,    fcr_pkg::START_MSG,   8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_BYTE,    8'h00,                8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_BYTE, fcr_pkg::QUERY_BYTE, 8'h00, 1'b1,
			'{1'b1, fcr_pkg::NACK_BYTE, 1'b1, 32'd129, 8'd199, 8'h00}},
		'{fcr_pkg::OP_BYTE,    8'h41,                8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_BYTE,    fcr_pkg::START_USERS, 8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_BYTE,    fcr_pkg::PING_BYTE,   8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_CONSUME, 8'h00,                8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_READ,    8'h00,                8'h04, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_BYTE,    fcr_pkg::START_PRIO,  8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_BYTE,    8'h00,                8'h00, 1'b0, NO_REPLY},
		'{fcr_pkg::OP_CONSUME, 8'h00, 8'h00, 1'b1,
			'{1'b0, 8'h00, 1'b0, 32'd129, 8'd200, 8'h00}}
	};

	localparam int RANDOM_ITEMS = 1300;
	localparam int CALM_FROM    = 1100;  // no idling on either side from here on
	localparam int LONG_HOLD_AT = 400;   // results seen before the long receiver hold
	localparam int LONG_HOLD    = 80;

	logic clk = 1'b0;
	logic arst_n;

	fcr_cmd_if cmd_ch ();
	fcr_rsp_if rsp_ch ();

	framed_command_receiver DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Bench copy of the receiver state
	logic [7:0]  shadow_store [256];
	bit          shadow_known [256];  // entries written since reset; only these are read
	logic [8:0]  shadow_fill;
	logic        shadow_pending;
	logic [31:0] shadow_users;
	logic [31:0] shadow_digits;
	logic [7:0]  shadow_timeout;

	reply_t replies_due [$];
	int     items_sent   = 0;
	int     results_seen = 0;
	int     mismatches   = 0;
	int     fail_count   = 0;
	bit     calm         = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Hard stop in case the block hangs
	initial begin
		#3000000;
		$display("Some tests failed");
		$finish;
	end

	// Advance the shadow state by one item and return the reply it causes
	function automatic reply_t next_reply(input fcr_pkg::op_t op, input logic [7:0] rx,
			input logic [7:0] idx);
		reply_t r;
		logic [7:0] head;
		r = '0;
		case (op)
			fcr_pkg::OP_BYTE: begin
				if (rx == fcr_pkg::PING_BYTE) begin
					r.tx_valid = 1'b1;
					r.tx_byte = fcr_pkg::PONG_BYTE;
					shadow_timeout = 8'(fcr_pkg::FCR_TIMEOUT_RELOAD);
				end else if (rx == fcr_pkg::QUERY_BYTE) begin
					r.tx_valid = 1'b1;
					r.tx_byte = shadow_pending ? fcr_pkg::NACK_BYTE : fcr_pkg::QUERY_BYTE;
				end else if (!shadow_pending) begin
					if (rx == fcr_pkg::START_USERS || rx == fcr_pkg::START_MSG
							|| rx == fcr_pkg::START_PRIO) begin
						// open a frame: head at position 0, fresh digit sum
						shadow_store[0] = rx;
						shadow_known[0] = 1'b1;
						shadow_fill = 9'd1;
						shadow_digits = '0;
					end else begin
						// drop the byte once the store is full, but still test completion
						if (shadow_fill < fcr_pkg::FCR_BUFFER_DEPTH) begin
							shadow_store[shadow_fill[7:0]] = rx;
							shadow_known[shadow_fill[7:0]] = 1'b1;
							if (shadow_fill >= 9'd2)
								shadow_digits = shadow_digits * 32'd10 + {24'd0, rx}
									- {24'd0, fcr_pkg::DIGIT_ZERO};
							shadow_fill = shadow_fill + 9'd1;
						end
						if (shadow_fill > 9'd1 && shadow_fill == {1'b0, shadow_store[1]} + 9'd2)
								begin
							head = shadow_store[0];
							r.tx_valid = 1'b1;
							r.tx_byte = head;
							if (head == fcr_pkg::START_USERS)
								shadow_users = shadow_digits;
							else if (head == fcr_pkg::START_MSG || head == fcr_pkg::START_PRIO)
								shadow_pending = 1'b1;
						end
					end
				end
			end
			fcr_pkg::OP_CONSUME: shadow_pending = 1'b0;
			fcr_pkg::OP_TICK: begin
				if (shadow_timeout != 8'd0)
					shadow_timeout = shadow_timeout - 8'd1;
			end
			default: begin
				if (idx < fcr_pkg::FCR_BUFFER_DEPTH)
					r.read_data = shadow_store[idx];
			end
		endcase
		r.message_pending = shadow_pending;
		r.user_count = shadow_users;
		r.idle_timeout = shadow_timeout;
		return r;
	endfunction

	function automatic logic [7:0] pick_start();
		case ($urandom_range(0, 2))
			0: return fcr_pkg::START_USERS;
			1: return fcr_pkg::START_MSG;
			default: return fcr_pkg::START_PRIO;
		endcase
	endfunction

	// Mostly decimal digits, now and then any byte at all
	function automatic logic [7:0] frame_byte();
		if ($urandom_range(0, 9) < 7)
			return fcr_pkg::DIGIT_ZERO + 8'($urandom_range(0, 9));
		return 8'($urandom);
	endfunction

	// Offer one item and hold it until it is taken. Called at a falling edge,
	// returns at the falling edge after the transfer with valid still high.
	task automatic send_item(input fcr_pkg::op_t op, input logic [7:0] rx,
			input logic [7:0] idx, input logic typed, input reply_t want);
		reply_t predicted;
		// fields the operation ignores still get random values
		if (op != fcr_pkg::OP_BYTE)
			rx = 8'($urandom);
		if (op != fcr_pkg::OP_READ)
			idx = 8'($urandom);
		if (!calm && $urandom_range(0, 6) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.op <= op;
		cmd_ch.rx_byte <= rx;
		cmd_ch.read_index <= idx;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		items_sent++;
		predicted = next_reply(op, rx, idx);
		replies_due.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] head, input int len, input int body);
		if (shadow_pending && $urandom_range(0, 9) < 8)
			send_item(fcr_pkg::OP_CONSUME, 8'h00, 8'h00, 1'b0, NO_REPLY);
		send_item(fcr_pkg::OP_BYTE, head, 8'h00, 1'b0, NO_REPLY);
		send_item(fcr_pkg::OP_BYTE, 8'(len), 8'h00, 1'b0, NO_REPLY);
		repeat (body) send_item(fcr_pkg::OP_BYTE, frame_byte(), 8'h00, 1'b0, NO_REPLY);
	endtask

	// Stimulus
	initial begin : sender
		int     pick;
		int     len;
		int     full_frames;
		logic [7:0] idx;
		full_frames = 0;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = fcr_pkg::OP_BYTE;
		cmd_ch.rx_byte = 8'h00;
		cmd_ch.read_index = 8'h00;
		for (int i = 0; i < 256; i++) begin
			shadow_store[i] = 8'h00;
			shadow_known[i] = 1'b0;
		end
		shadow_fill = '0;
		shadow_pending = 1'b0;
		shadow_users = '0;
		shadow_digits = '0;
		shadow_timeout = '0;
		wait (arst_n === 1'b1);
		@(negedge clk);

		// walk the directed table
		for (int i = 0; i < N_ROWS; i++)
			send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].idx,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

		// pause until the pipeline has drained completely
		cmd_ch.valid <= 1'b0;
		wait (replies_due.size() == 0);
		@(negedge clk);
		items_sent = 0;

		while (items_sent < RANDOM_ITEMS) begin
			calm = (items_sent >= CALM_FROM);
			pick = $urandom_range(0, 99);
			if (full_frames == 0 || (pick < 2 && full_frames < 2)) begin
				// fill the whole store, then keep going past the end
				full_frames++;
				if (shadow_pending)
					send_item(fcr_pkg::OP_CONSUME, 8'h00, 8'h00, 1'b0, NO_REPLY);
				send_frame(pick_start(), $urandom_range(254, 255),
					254 + $urandom_range(1, 4));
			end else if (pick < 55) begin
				// complete frame of a short length
				len = $urandom_range(0, 12);
				send_frame(pick_start(), len, len);
			end else if (pick < 70) begin
				// broken frame: fewer bytes than the length announces
				len = $urandom_range(2, 10);
				send_frame(pick_start(), len, $urandom_range(0, len - 1));
			end else begin
				case ($urandom_range(0, 5))
					0: send_item(fcr_pkg::OP_TICK, 8'h00, 8'h00, 1'b0, NO_REPLY);
					1: send_item(fcr_pkg::OP_CONSUME, 8'h00, 8'h00, 1'b0, NO_REPLY);
					2: begin
						do
							idx = 8'($urandom);
						while (!shadow_known[idx]);
						send_item(fcr_pkg::OP_READ, 8'h00, idx, 1'b0, NO_REPLY);
					end
					3: send_item(fcr_pkg::OP_BYTE, fcr_pkg::PING_BYTE, 8'h00, 1'b0, NO_REPLY);
					4: send_item(fcr_pkg::OP_BYTE, fcr_pkg::QUERY_BYTE, 8'h00, 1'b0, NO_REPLY);
					default: send_item(fcr_pkg::OP_BYTE, 8'($urandom), 8'h00, 1'b0, NO_REPLY);
				endcase
			end
		end

		cmd_ch.valid <= 1'b0;
		wait (replies_due.size() == 0);
		// let any stray result show up before the verdict
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Receiver: short random stalls, one long hold so the block backs up into its input
	initial begin : receiver
		int  hold_left;
		bit  long_done;
		hold_left = 0;
		long_done = 1'b0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!long_done && results_seen >= LONG_HOLD_AT) begin
				long_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 6) == 0) begin
				hold_left = $urandom_range(0, 3);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			got = '{rsp_ch.tx_valid, rsp_ch.tx_byte, rsp_ch.message_pending,
				rsp_ch.user_count, rsp_ch.idle_timeout, rsp_ch.read_data};
			if (replies_due.size() == 0) begin
				fail_count++;
				mismatches++;
				if (mismatches <= 10) begin
					$write("ERROR: result with nothing expected: tx %0b/%02h pend %0b ",
						got.tx_valid, got.tx_byte, got.message_pending);
					$display("users %0d timeout %0d rd %02h",
						got.user_count, got.idle_timeout, got.read_data);
				end
			end else begin
				want = replies_due.pop_front();
				if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte
						|| got.message_pending !== want.message_pending
						|| got.user_count !== want.user_count
						|| got.idle_timeout !== want.idle_timeout
						|| got.read_data !== want.read_data) begin
					fail_count++;
					mismatches++;
					if (mismatches <= 10) begin
						$write("ERROR: result %0d: exp tx %0b/%02h pend %0b users %0d ",
							results_seen, want.tx_valid, want.tx_byte, want.message_pending,
							want.user_count);
						$write("timeout %0d rd %02h, ", want.idle_timeout, want.read_data);
						$write("got tx %0b/%02h pend %0b users %0d ",
							got.tx_valid, got.tx_byte, got.message_pending, got.user_count);
						$display("timeout %0d rd %02h", got.idle_timeout, got.read_data);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire
